// ===== src/box_blur_byte_window_unit_assert.svh =====
`ifndef BOX_BLUR_BYTE_WINDOW_UNIT_ASSERT_SVH
`define BOX_BLUR_BYTE_WINDOW_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BBW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BBW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bbw_pkg.sv =====
package bbw_pkg;

    localparam int MAX_KERNEL    = 23;
    localparam int MAX_ROW_BYTES = 4096;
    localparam int LS_DEPTH      = (MAX_KERNEL - 1) * MAX_ROW_BYTES + MAX_KERNEL;
    localparam int LS_AW         = $clog2(LS_DEPTH);
    localparam int POS_W         = 28;
    localparam int KS_W          = 5;
    localparam int RB_W          = 13;
    localparam int RC_W          = 16;
    localparam int COL_W         = 12;
    localparam int M_W           = 4;
    localparam int WIN_W         = 5;
    localparam int D_W           = 17;
    localparam int SUM_W         = 18;
    localparam int KK_W          = 10;
    localparam int DCNT_W        = $clog2(SUM_W);
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT   = 2'd2;

    localparam logic ACTION_PIXEL = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_PASS,
        S_PASS_WAIT,
        S_ACC,
        S_DIV,
        S_OUT
    } state_t;

endpackage

// ===== src/box_blur_byte_window_unit.sv =====
// Box blur over a raster byte stream.
// Input channel s_*: one transaction per byte; s_tuser = 0 carries a pixel byte in
// s_tdata, s_tuser = 1 is a drain transaction that only pulls out pending results.
// Output channel m_*: filtered or passed-through bytes in raster order, m_tlast on
// the last byte of the frame. The cfg_* port writes kernel_size, row_bytes and
// row_count; any write restarts the frame. Write only while the block is idle.
// Bytes go into a single-port-write line store; results are produced from it once
// M rows plus M bytes have arrived (M = (kernel_size-1)/2), drains flush the tail.
// One transaction is processed at a time. A passed-through result is read from
// the line store into the output register; a filtered one takes one line store
// read per window byte, then a shift-subtract divider. A transaction that
// yields no result frees the input once the decision is made.
// If the receiver stalls, the result holds in the output register and s_tready
// stays low until it is taken. Synchronous reset loads kernel_size 3,
// row_bytes 4096, row_count 1 and returns to the frame start; the line store is
// not cleared, since results only read bytes written earlier in the frame.
module box_blur_byte_window_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] pixel_byte
    input  logic                             s_tuser,   // [0] action
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // [7:0] out_byte
    output logic                             m_tlast,
    input  logic                             cfg_wr_en,
    input  logic [bbw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bbw_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import bbw_pkg::*;

    function automatic logic [LS_AW-1:0] addr_add(input logic [LS_AW-1:0] a,
                                                  input logic [RB_W-1:0] n);
        logic [LS_AW:0] s;
        s = {1'b0, a} + (LS_AW+1)'(n);
        if (s >= (LS_AW+1)'(LS_DEPTH)) begin
            s = s - (LS_AW+1)'(LS_DEPTH);
        end
        return s[LS_AW-1:0];
    endfunction

    state_t state_reg, state_next;

    logic [KS_W-1:0]   kernel_reg;
    logic [RB_W-1:0]   row_bytes_reg;
    logic [RC_W-1:0]   row_count_reg;

    // geometry derived from the registers, registered in the cycle after they change
    logic [RB_W-1:0]   w_reg, w_next;
    logic [M_W-1:0]    m_reg, m_next;
    logic [WIN_W-1:0]  win_reg, win_next;
    logic              active_reg, active_next;
    logic [D_W-1:0]    d_reg, d_next;
    logic [POS_W-1:0]  total_reg, total_next;
    logic [KK_W-1:0]   kk_reg, kk_next;
    logic [RC_W-1:0]   hm_reg, hm_next;
    logic [RB_W-1:0]   wm_reg, wm_next;
    logic [RC_W-1:0]   h_next;

    logic [POS_W-1:0]  in_pos_reg, out_pos_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [RC_W-1:0]   out_row_reg;
    logic [LS_AW-1:0]  waddr_reg, rptr_reg;
    logic [LS_AW-1:0]  row_base_reg, cur_addr_reg;
    logic [WIN_W-1:0]  a_reg, b_reg;
    logic              issue_reg, pend_reg;
    logic [SUM_W-1:0]  sum_reg, quo_reg;
    logic [KK_W-1:0]   rem_reg;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;

    logic [7:0]        ls_mem [LS_DEPTH];
    logic [7:0]        rd_data_reg;
    logic [LS_AW-1:0]  rd_addr;
    logic              ls_we;

    logic              s_fire, m_fire, in_take;
    logic              emit_c, filt_c;
    logic [POS_W:0]    need_c;
    logic [LS_AW-1:0]  base_c, row_step_c;
    logic [KK_W:0]     div_t;
    logic              div_bit;
    logic [SUM_W-1:0]  quo_step;

    assign s_fire  = s_tvalid && s_tready;
    assign m_fire  = m_tvalid && m_tready;
    assign in_take = s_fire && (s_tuser == ACTION_PIXEL) && (in_pos_reg < total_reg);

    // geometry
    always_comb begin
        w_next = row_bytes_reg;
        if (row_bytes_reg == '0) begin
            w_next = RB_W'(1);
        end else if (row_bytes_reg > RB_W'(MAX_ROW_BYTES)) begin
            w_next = RB_W'(MAX_ROW_BYTES);
        end
        h_next      = (row_count_reg == '0) ? RC_W'(1) : row_count_reg;
        m_next      = (kernel_reg == '0) ? '0 : M_W'((kernel_reg - KS_W'(1)) >> 1);
        win_next    = {m_next, 1'b1};
        active_next = (kernel_reg != '0) && (kernel_reg <= KS_W'(MAX_KERNEL))
                      && (RB_W'(win_next) <= w_next) && (RC_W'(win_next) <= h_next);
        d_next      = active_next ? D_W'(m_next * w_next) + D_W'(m_next) : '0;
        total_next  = POS_W'(w_next * h_next);
        kk_next     = KK_W'(kernel_reg * kernel_reg);
        hm_next     = h_next - RC_W'(m_next);
        wm_next     = w_next - RB_W'(m_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg      <= RB_W'(MAX_ROW_BYTES);
            m_reg      <= M_W'(1);
            win_reg    <= WIN_W'(3);
            active_reg <= 1'b0;
            d_reg      <= '0;
            total_reg  <= POS_W'(MAX_ROW_BYTES);
            kk_reg     <= KK_W'(9);
            hm_reg     <= '0;
            wm_reg     <= RB_W'(MAX_ROW_BYTES - 1);
        end else begin
            w_reg      <= w_next;
            m_reg      <= m_next;
            win_reg    <= win_next;
            active_reg <= active_next;
            d_reg      <= d_next;
            total_reg  <= total_next;
            kk_reg     <= kk_next;
            hm_reg     <= hm_next;
            wm_reg     <= wm_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_reg    <= KS_W'(3);
            row_bytes_reg <= RB_W'(MAX_ROW_BYTES);
            row_count_reg <= RC_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_KERNEL_SIZE: kernel_reg    <= cfg_wdata[KS_W-1:0];
                CFG_ROW_BYTES:   row_bytes_reg <= cfg_wdata[RB_W-1:0];
                CFG_ROW_COUNT:   row_count_reg <= cfg_wdata[RC_W-1:0];
                default: ;
            endcase
        end
    end

    // result decision for the current output position
    always_comb begin
        need_c = {1'b0, out_pos_reg} + (POS_W+1)'(d_reg);
        emit_c = (out_pos_reg < total_reg)
                 && (((POS_W+1)'(in_pos_reg) > need_c) || (in_pos_reg >= total_reg));
        filt_c = active_reg
                 && (out_row_reg >= RC_W'(m_reg)) && (out_row_reg < hm_reg)
                 && (RB_W'(out_col_reg) >= RB_W'(m_reg)) && (RB_W'(out_col_reg) < wm_reg);
        if (rptr_reg >= LS_AW'(d_reg)) begin
            base_c = rptr_reg - LS_AW'(d_reg);
        end else begin
            base_c = LS_AW'((LS_AW+1)'(rptr_reg) + (LS_AW+1)'(LS_DEPTH)
                            - (LS_AW+1)'(d_reg));
        end
        row_step_c = addr_add(row_base_reg, w_reg);
        div_t      = {rem_reg, quo_reg[SUM_W-1]};
        div_bit    = (div_t >= (KK_W+1)'(kk_reg));
        quo_step   = {quo_reg[SUM_W-2:0], div_bit};
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (s_fire) state_next = S_DECIDE;
            S_DECIDE: begin
                if (!emit_c) begin
                    state_next = S_IDLE;
                end else if (filt_c) begin
                    state_next = S_ACC;
                end else begin
                    state_next = S_PASS;
                end
            end
            S_PASS:      state_next = S_PASS_WAIT;
            S_PASS_WAIT: state_next = S_OUT;
            S_ACC:       if (!issue_reg && !pend_reg) state_next = S_DIV;
            S_DIV:       if (div_cnt_reg == DCNT_W'(SUM_W - 1)) state_next = S_OUT;
            S_OUT:       if (m_tready) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready = (state_reg == S_IDLE);
        m_tvalid = (state_reg == S_OUT);
        ls_we    = in_take;
        rd_addr  = (state_reg == S_PASS) ? rptr_reg : cur_addr_reg;
    end

    assign m_tdata = out_byte_reg;
    assign m_tlast = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ls_we) begin
            ls_mem[waddr_reg] <= s_tdata;
        end
        rd_data_reg <= ls_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_pos_reg   <= '0;
            out_pos_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            waddr_reg    <= '0;
            rptr_reg     <= '0;
            issue_reg    <= 1'b0;
            pend_reg     <= 1'b0;
            out_last_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            in_pos_reg  <= '0;
            out_pos_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            waddr_reg   <= '0;
            rptr_reg    <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (in_take) begin
                        in_pos_reg <= in_pos_reg + POS_W'(1);
                        waddr_reg  <= addr_add(waddr_reg, RB_W'(1));
                    end
                end
                S_DECIDE: begin
                    out_last_reg <= (out_pos_reg + POS_W'(1) == total_reg);
                    row_base_reg <= base_c;
                    cur_addr_reg <= base_c;
                    a_reg        <= '0;
                    b_reg        <= '0;
                    sum_reg      <= '0;
                    issue_reg    <= 1'b1;
                    pend_reg     <= 1'b0;
                end
                S_PASS_WAIT: out_byte_reg <= rd_data_reg;
                S_ACC: begin
                    pend_reg <= issue_reg;
                    if (pend_reg) begin
                        sum_reg <= sum_reg + SUM_W'(rd_data_reg);
                    end
                    if (issue_reg) begin
                        if (b_reg == win_reg - WIN_W'(1)) begin
                            b_reg        <= '0;
                            a_reg        <= a_reg + WIN_W'(1);
                            row_base_reg <= row_step_c;
                            cur_addr_reg <= row_step_c;
                            if (a_reg == win_reg - WIN_W'(1)) begin
                                issue_reg <= 1'b0;
                            end
                        end else begin
                            b_reg        <= b_reg + WIN_W'(1);
                            cur_addr_reg <= addr_add(cur_addr_reg, RB_W'(1));
                        end
                    end
                    if (!issue_reg && !pend_reg) begin
                        quo_reg     <= sum_reg;
                        rem_reg     <= '0;
                        div_cnt_reg <= '0;
                    end
                end
                S_DIV: begin
                    // shift-subtract, one quotient bit per cycle
                    rem_reg     <= div_bit ? KK_W'(div_t - (KK_W+1)'(kk_reg))
                                           : div_t[KK_W-1:0];
                    quo_reg     <= quo_step;
                    div_cnt_reg <= div_cnt_reg + DCNT_W'(1);
                    if (div_cnt_reg == DCNT_W'(SUM_W - 1)) begin
                        out_byte_reg <= quo_step[7:0];
                    end
                end
                S_OUT: begin
                    if (m_tready) begin
                        if (out_last_reg) begin
                            in_pos_reg  <= '0;
                            out_pos_reg <= '0;
                            out_col_reg <= '0;
                            out_row_reg <= '0;
                            waddr_reg   <= '0;
                            rptr_reg    <= '0;
                        end else begin
                            out_pos_reg <= out_pos_reg + POS_W'(1);
                            rptr_reg    <= addr_add(rptr_reg, RB_W'(1));
                            if (RB_W'(out_col_reg) + RB_W'(1) >= w_reg) begin
                                out_col_reg <= '0;
                                out_row_reg <= out_row_reg + RC_W'(1);
                            end else begin
                                out_col_reg <= out_col_reg + COL_W'(1);
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

`include "box_blur_byte_window_unit_assert.svh"

    `BBW_ASSERT_NOW(a_out_behind_in, 1'b1, out_pos_reg <= in_pos_reg, "output ahead of input")
    `BBW_ASSERT_NOW(a_write_idle, ls_we, state_reg == S_IDLE, "line store write outside idle")
    `BBW_ASSERT_NOW(a_div_nonzero, state_reg == S_DIV, kk_reg != '0, "divide by zero")
    `BBW_ASSERT_NEXT(a_frame_restart, m_fire && m_tlast && !cfg_wr_en,
                     (out_pos_reg == '0) && (in_pos_reg == '0), "frame not restarted")

endmodule

// ===== tb/tb_box_blur_byte_window_unit.sv =====
module tb_box_blur_byte_window_unit;
    import bbw_pkg::*;

    localparam logic ACTION_DRAIN = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 600;

    typedef struct {
        logic [7:0] pix;
        logic       last;
    } blur_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic m_tlast;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    box_blur_byte_window_unit dut (.*);

    always #10 aclk = ~aclk;

    // blur predictor state
    logic [7:0] pixel_store [LS_DEPTH];
    logic [KS_W-1:0] kern_reg;
    logic [RB_W-1:0] rowb_reg;
    logic [RC_W-1:0] rowc_reg;
    longint in_col, in_row, out_pos;
    blur_result_t pending_q[$];
    int err_count = 0;
    int item_count = 0;
    int burst_left = 0;
    int hold_cycles = 0;

    function automatic void restart_frame();
        in_col = 0;
        in_row = 0;
        out_pos = 0;
    endfunction

    function automatic void get_geometry(output longint w, output longint h,
                                         output longint m, output bit act);
        longint k;
        w = rowb_reg;
        h = rowc_reg;
        if (w == 0) w = 1;
        if (w > MAX_ROW_BYTES) w = MAX_ROW_BYTES;
        if (h == 0) h = 1;
        k = kern_reg;
        m = (k >= 1) ? (k - 1) / 2 : 0;
        act = k >= 1 && k <= MAX_KERNEL && 2 * m + 1 <= w && 2 * m + 1 <= h;
    endfunction

    function automatic longint frame_total();
        longint w, h, m;
        bit act;
        get_geometry(w, h, m, act);
        return w * h;
    endfunction

    // true once the whole frame went in but results are still owed
    function automatic bit flush_pending();
        longint w, h, m;
        bit act;
        get_geometry(w, h, m, act);
        return (in_row * w + in_col >= w * h) && out_pos < w * h;
    endfunction

    function automatic void predict_blur(logic action, logic [7:0] pix);
        longint w, h, m, d, total, in_p, p, r, c;
        bit act;
        int sum;
        blur_result_t res;
        get_geometry(w, h, m, act);
        total = w * h;
        d = act ? m * w + m : 0;
        in_p = in_row * w + in_col;
        if (action == ACTION_PIXEL && in_p < total) begin
            pixel_store[in_p % LS_DEPTH] = pix;
            in_p++;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        end
        p = out_pos;
        if (p >= total || !(in_p > p + d || in_p >= total)) return;
        r = p / w;
        c = p % w;
        if (act && r >= m && r < h - m && c >= m && c < w - m) begin
            sum = 0;
            for (longint a = 0; a <= 2 * m; a++)
                for (longint b = 0; b <= 2 * m; b++)
                    sum += pixel_store[(p - d + a * w + b) % LS_DEPTH];
            res.pix = 8'(sum / (int'(kern_reg) * int'(kern_reg)));
        end else begin
            res.pix = pixel_store[p % LS_DEPTH];
        end
        res.last = (p + 1 == total);
        pending_q.push_back(res);
        if (res.last) restart_frame();
        else out_pos = p + 1;
    endfunction

    // result checker
    always @(posedge aclk) begin
        blur_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_q.size() == 0) begin
                $error("unexpected result out_byte=%0d frame_end=%0b", m_tdata, m_tlast);
                err_count++;
            end else begin
                exp_res = pending_q.pop_front();
                if (m_tdata !== exp_res.pix) begin
                    $error("out_byte expected %0d actual %0d", exp_res.pix, m_tdata);
                    err_count++;
                end
                if (m_tlast !== exp_res.last) begin
                    $error("frame_end expected %0b actual %0b", exp_res.last, m_tlast);
                    err_count++;
                end
            end
        end
    end

    // receiver stall pattern, switched periodically among four modes, plus long hold-offs
    always @(posedge aclk) begin
        int unsigned cyc;
        int unsigned stall_mode;
        cyc++;
        if (cyc % 64 == 0) stall_mode = $urandom_range(0, 3);
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_tready <= 1'b0;
        end else begin
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 9) < 7);
                2: m_tready <= ($urandom_range(0, 9) < 3);
                default: m_tready <= cyc[2];
            endcase
        end
    end

    task automatic send_item(logic action, logic [7:0] pix);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= action;
        s_tdata <= pix;
        do @(posedge aclk); while (!s_tready);
        predict_blur(action, pix);
        item_count++;
    endtask

    // hold the input until every expected result is out and the block settles
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (pending_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_KERNEL_SIZE: kern_reg = val[KS_W-1:0];
            CFG_ROW_BYTES:   rowb_reg = val[RB_W-1:0];
            CFG_ROW_COUNT:   rowc_reg = val[RC_W-1:0];
            default: ;
        endcase
        restart_frame();
    endtask

    task automatic set_frame(int k, int w, int h);
        write_reg(CFG_KERNEL_SIZE, CFG_DATA_W'(k));
        write_reg(CFG_ROW_BYTES, CFG_DATA_W'(w));
        write_reg(CFG_ROW_COUNT, CFG_DATA_W'(h));
    endtask

    // one frame of random bytes with optional noise, then drains to flush it
    task automatic run_frame(int noise_pct);
        longint total;
        total = frame_total();
        for (longint i = 0; i < total; i++) begin
            if ($urandom_range(0, 99) < noise_pct) send_item(ACTION_DRAIN, 8'($urandom));
            send_item(ACTION_PIXEL, 8'($urandom));
        end
        while (flush_pending()) begin
            if ($urandom_range(0, 99) < noise_pct) send_item(ACTION_PIXEL, 8'($urandom));
            else send_item(ACTION_DRAIN, 8'($urandom));
        end
    endtask

    task automatic test_directed();
        // extremes, mid-frame drain, dropped byte after input complete
        set_frame(3, 4, 3);
        send_item(ACTION_PIXEL, 8'hFF);
        send_item(ACTION_DRAIN, 8'hFF);
        for (int i = 0; i < 10; i++) send_item(ACTION_PIXEL, i[0] ? 8'h00 : 8'hFF);
        send_item(ACTION_PIXEL, 8'hAA);
        send_item(ACTION_PIXEL, 8'h33);
        while (flush_pending()) send_item(ACTION_DRAIN, 8'h55);
        // even kernel, disabled kernels, degenerate geometry
        set_frame(4, 4, 3);
        run_frame(0);
        set_frame(0, 3, 1);
        run_frame(0);
        set_frame(24, 3, 1);
        run_frame(0);
        write_reg(CFG_KERNEL_SIZE, 16'hFFFF);
        write_reg(CFG_ROW_COUNT, 16'hFFFF);
        write_reg(CFG_UNUSED, 16'hFFFF);
        set_frame(1, 0, 0);
        run_frame(0);
        // abort mid-frame with a write beyond the register list
        set_frame(3, 5, 3);
        for (int i = 0; i < 6; i++) send_item(ACTION_PIXEL, 8'($urandom));
        write_reg(CFG_UNUSED, 16'h0000);
        run_frame(0);
    endtask

    task automatic test_extremes();
        // clamped row width: stream part of a row, then abort the frame
        set_frame(1, 16'h1FFF, 1);
        for (int i = 0; i < 64; i++) send_item(ACTION_PIXEL, 8'($urandom));
        set_frame(23, 23, 23);
        run_frame(0);
    endtask

    task automatic test_backpressure();
        set_frame(1, 16, 8);
        hold_cycles = 3000;
        run_frame(0);
        wait_idle();
        set_frame(3, 8, 6);
        for (int i = 0; i < 20; i++) send_item(ACTION_PIXEL, 8'($urandom));
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_q.size() != 0);
        run_frame(0);
    endtask

    task automatic test_random();
        int k, w, h;
        while (item_count < 1500) begin
            case ($urandom_range(0, 9))
                0: k = 2 * $urandom_range(0, 15);
                1: k = $urandom_range(7, 23) | 1;
                default: k = 2 * $urandom_range(0, 2) + 1;
            endcase
            w = $urandom_range(1, 30);
            h = $urandom_range(1, 20);
            if (k > 9) begin
                w = $urandom_range(k, k + 4);
                h = $urandom_range(k, k + 2);
            end
            set_frame(k, w, h);
            run_frame($urandom_range(0, 3) == 0 ? 10 : 0);
        end
    endtask

    initial begin
        kern_reg = 3;
        rowb_reg = 4096;
        rowc_reg = 1;
        restart_frame();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_extremes();
        test_backpressure();
        test_random();
        wait_idle();
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #400000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
